// File: src/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned CNT_W        = $clog2(RESULT_LIMIT);
  localparam int unsigned HANDLE_W     = 16;
  localparam int unsigned TIME_W       = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } stq_op_e;

  typedef enum logic [2:0] {
    KIND_DONE      = 3'd0,
    KIND_EXPIRED   = 3'd1,
    KIND_NONE      = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_NOT_FOUND = 3'd4,
    KIND_DUPLICATE = 3'd5
  } stq_kind_e;

  typedef enum logic [1:0] {
    CMD_HOLD        = 2'd0,
    CMD_INSERT      = 2'd1,
    CMD_REMOVE_KEY  = 2'd2,
    CMD_REMOVE_HEAD = 2'd3
  } stq_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } stq_state_e;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   expiry;
  } stq_entry_t;

  typedef struct packed {
    stq_cmd_e            cmd;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   expiry;
  } stq_ctl_t;

endpackage

// File: src/stq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain: holds an entry, compares it with the key and
// shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module stq_cell import stq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stq_ctl_t   ctl_i,
  input  stq_entry_t left_i,
  input  logic       left_le_i,
  input  logic       rm_i,
  input  stq_entry_t right_i,
  output stq_entry_t ent_o,
  output logic       le_o,
  output logic       rm_o,
  output logic       match_o
);

  stq_entry_t ent_q, ent_d;

  assign le_o    = ent_q.valid && (ent_q.expiry <= ctl_i.expiry);
  assign match_o = ent_q.valid && (ent_q.handle == ctl_i.handle);
  assign rm_o    = rm_i || ((ctl_i.cmd == CMD_REMOVE_KEY) && match_o);
  assign ent_o   = ent_q;

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.cmd)
      CMD_INSERT: begin
        if (!le_o) begin
          if (left_le_i) begin
            ent_d.valid  = 1'b1;
            ent_d.handle = ctl_i.handle;
            ent_d.expiry = ctl_i.expiry;
          end else begin
            ent_d = left_i;
          end
        end
      end
      CMD_REMOVE_KEY, CMD_REMOVE_HEAD: begin
        if (rm_o) begin
          ent_d = right_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

// File: src/sorted_timer_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// Timer list kept in ascending expiry order in a chain of shifting cells.
// Insert, delete and a tick with nothing due are done in ST_EXEC; adjust of
// a present handle first removes it, then places it anew.
// A tick emits one expired item per cycle unless stalled, up to RESULT_LIMIT.
// Throughput: one item at a time; next item accepted once the last result
// of the current one is registered. Reset clears all slots at once.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top import stq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [TIME_W-1:0]   expiry_time_i,
  input  logic [TIME_W-1:0]   now_time_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          kind_o,
  output logic [HANDLE_W-1:0] result_handle_o,
  output logic [TIME_W-1:0]   result_expiry_o,
  output logic                last_o
);

  stq_state_e          state_q, state_d;
  stq_op_e             op_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [TIME_W-1:0]   expiry_q;
  logic [TIME_W-1:0]   now_q;
  logic [CNT_W-1:0]    n_q, n_d;

  logic                out_valid_q;
  stq_kind_e           kind_q;
  logic [HANDLE_W-1:0] res_handle_q;
  logic [TIME_W-1:0]   res_expiry_q;
  logic                last_q;

  stq_ctl_t   ctl;
  stq_entry_t ent [CAPACITY+1];
  logic       le_vec [CAPACITY+1];
  logic       rm_vec [CAPACITY+1];
  logic [CAPACITY-1:0] match_vec;

  logic                found, full, head_due, next_due, out_free, accept;
  logic [TIME_W-1:0]   match_exp;
  logic                emit, emit_last;
  stq_kind_e           emit_kind;
  logic [HANDLE_W-1:0] emit_handle;
  logic [TIME_W-1:0]   emit_expiry;

  // chain boundaries
  assign ent[CAPACITY] = '0;
  assign le_vec[0]     = 1'b1;
  assign rm_vec[0]     = (ctl.cmd == CMD_REMOVE_HEAD);

  stq_entry_t left_ent [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_ent[i] = '0;
    end else begin : g_body
      assign left_ent[i] = ent[i-1];
    end
    stq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .left_i    (left_ent[i]),
      .left_le_i (le_vec[i]),
      .rm_i      (rm_vec[i]),
      .right_i   (ent[i+1]),
      .ent_o     (ent[i]),
      .le_o      (le_vec[i+1]),
      .rm_o      (rm_vec[i+1]),
      .match_o   (match_vec[i])
    );
  end

  assign found    = |match_vec;
  assign full     = ent[CAPACITY-1].valid;
  assign head_due = ent[0].valid && (ent[0].expiry <= now_q);
  assign next_due = ent[1].valid && (ent[1].expiry <= now_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    match_exp = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_exp = match_exp | ({TIME_W{match_vec[i]}} & ent[i].expiry);
    end
  end

  always_comb begin
    ctl.cmd     = CMD_HOLD;
    ctl.handle  = handle_q;
    ctl.expiry  = expiry_q;
    state_d     = state_q;
    n_d         = n_q;
    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_kind   = KIND_DONE;
    emit_handle = handle_q;
    emit_expiry = expiry_q;
    if (accept) begin
      state_d = ST_EXEC;
    end else if ((state_q == ST_EXEC) && out_free) begin
      case (op_q)
        OP_INSERT, OP_ADJUST: begin
          if (found && (op_q == OP_INSERT)) begin
            emit        = 1'b1;
            emit_kind   = KIND_DUPLICATE;
            emit_expiry = match_exp;
          end else if (found) begin
            ctl.cmd = CMD_REMOVE_KEY;
          end else if (full) begin
            emit      = 1'b1;
            emit_kind = KIND_FULL;
          end else begin
            ctl.cmd   = CMD_INSERT;
            emit      = 1'b1;
            emit_kind = KIND_DONE;
          end
        end
        OP_DELETE: begin
          emit = 1'b1;
          if (found) begin
            ctl.cmd     = CMD_REMOVE_KEY;
            emit_kind   = KIND_DONE;
            emit_expiry = match_exp;
          end else begin
            emit_kind   = KIND_NOT_FOUND;
            emit_expiry = '0;
          end
        end
        OP_TICK: begin
          emit = 1'b1;
          if (head_due) begin
            ctl.cmd     = CMD_REMOVE_HEAD;
            emit_kind   = KIND_EXPIRED;
            emit_handle = ent[0].handle;
            emit_expiry = ent[0].expiry;
            emit_last   = (n_q == CNT_W'(RESULT_LIMIT - 1)) || !next_due;
            n_d         = n_q + CNT_W'(1);
          end else begin
            emit_kind   = KIND_NONE;
            emit_handle = '0;
            emit_expiry = '0;
          end
        end
        default: ctl.cmd = CMD_HOLD;
      endcase
      if (emit && emit_last) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= accept ? '0 : n_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= stq_op_e'(opcode_i);
      handle_q <= handle_i;
      expiry_q <= expiry_time_i;
      now_q    <= now_time_i;
    end
    if (emit) begin
      kind_q       <= emit_kind;
      res_handle_q <= emit_handle;
      res_expiry_q <= emit_expiry;
      last_q       <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign result_handle_o = res_handle_q;
  assign result_expiry_o = res_expiry_q;
  assign last_o          = last_q;

endmodule

// File: test/sorted_timer_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_top_test
// Self-checking bench for the sorted timer queue. A directed part covers the
// empty store, equal-expiry ordering, adjust in both directions, duplicates,
// a full store and a full expiry burst. A random part follows, first with no
// idling, then with random gaps and stalls on both channels. Every item that
// is accepted is run through a behavioral copy of the timer list. Each result
// is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top_test import stq_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int POOL_SIZE      = 20;

  typedef struct {
    stq_kind_e           kind;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   expiry;
    logic                last;
  } timer_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [1:0]          opcode_i      = '0;
  logic [HANDLE_W-1:0] handle_i      = '0;
  logic [TIME_W-1:0]   expiry_time_i = '0;
  logic [TIME_W-1:0]   now_time_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [2:0]          kind_o;
  logic [HANDLE_W-1:0] result_handle_o;
  logic [TIME_W-1:0]   result_expiry_o;
  logic                last_o;

  // behavioral copy of the timer list
  logic [HANDLE_W-1:0] list_handle [CAPACITY];
  logic [TIME_W-1:0]   list_expiry [CAPACITY];
  int                  list_count;

  timer_result_t       due_results[$];
  logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];
  logic [TIME_W-1:0]   clock_now;

  bit quiet_run       = 1'b0;
  int mismatch_count  = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int expired_seen    = 0;
  int idle_cycles     = 0;

  sorted_timer_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .handle_i       (handle_i),
    .expiry_time_i  (expiry_time_i),
    .now_time_i     (now_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .result_handle_o(result_handle_o),
    .result_expiry_o(result_expiry_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int list_find(logic [HANDLE_W-1:0] h);
    for (int i = 0; i < list_count; i++) begin
      if (list_handle[i] == h) return i;
    end
    return -1;
  endfunction

  task automatic list_take(int pos);
    for (int i = pos; i + 1 < list_count; i++) begin
      list_handle[i] = list_handle[i+1];
      list_expiry[i] = list_expiry[i+1];
    end
    list_count--;
    list_handle[list_count] = '0;
    list_expiry[list_count] = '0;
  endtask

  task automatic list_place(logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] e);
    int pos;
    pos = 0;
    while (pos < list_count && list_expiry[pos] <= e) pos++;
    for (int i = list_count; i > pos; i--) begin
      list_handle[i] = list_handle[i-1];
      list_expiry[i] = list_expiry[i-1];
    end
    list_handle[pos] = h;
    list_expiry[pos] = e;
    list_count++;
  endtask

  task automatic add_due(stq_kind_e kind, logic [HANDLE_W-1:0] h,
                         logic [TIME_W-1:0] e, logic last);
    timer_result_t r;
    r.kind   = kind;
    r.handle = h;
    r.expiry = e;
    r.last   = last;
    due_results.push_back(r);
  endtask

  task automatic predict_timer_op(stq_op_e op, logic [HANDLE_W-1:0] h,
                                  logic [TIME_W-1:0] e, logic [TIME_W-1:0] now);
    int pos;
    int n;
    timer_result_t tail;
    case (op)
      OP_INSERT, OP_ADJUST: begin
        pos = list_find(h);
        if (pos >= 0 && op == OP_INSERT) begin
          add_due(KIND_DUPLICATE, h, list_expiry[pos], 1'b1);
        end else begin
          if (pos >= 0) list_take(pos);
          if (list_count >= CAPACITY) begin
            add_due(KIND_FULL, h, e, 1'b1);
          end else begin
            list_place(h, e);
            add_due(KIND_DONE, h, e, 1'b1);
          end
        end
      end
      OP_DELETE: begin
        pos = list_find(h);
        if (pos < 0) begin
          add_due(KIND_NOT_FOUND, h, '0, 1'b1);
        end else begin
          add_due(KIND_DONE, h, list_expiry[pos], 1'b1);
          list_take(pos);
        end
      end
      default: begin
        n = 0;
        while (n < RESULT_LIMIT && list_count > 0 && list_expiry[0] <= now) begin
          add_due(KIND_EXPIRED, list_handle[0], list_expiry[0], 1'b0);
          list_take(0);
          n++;
        end
        if (n == 0) begin
          add_due(KIND_NONE, '0, '0, 1'b1);
        end else begin
          tail = due_results.pop_back();
          tail.last = 1'b1;
          due_results.push_back(tail);
        end
      end
    endcase
  endtask

  // entered at a falling edge; returns at the falling edge after the item is
  // taken, with valid still high so the caller either sends or rests the input
  task automatic send_item(stq_op_e op, logic [HANDLE_W-1:0] h,
                           logic [TIME_W-1:0] e, logic [TIME_W-1:0] now);
    while (!quiet_run && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    handle_i      <= h;
    expiry_time_i <= e;
    now_time_i    <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_accepted++;
    predict_timer_op(op, h, e, now);
    @(negedge clk_i);
  endtask

  task automatic rest_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    rest_input();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_empty_store();
    send_item(OP_TICK,   16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_DELETE, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_order_and_adjust();
    send_item(OP_INSERT, 16'h0000, 32'h0000_0000, 32'h0);
    send_item(OP_INSERT, 16'hffff, 32'hffff_ffff, 32'h0);
    send_item(OP_INSERT, 16'h0000, 32'h0000_0123, 32'h0);
    send_item(OP_ADJUST, 16'h1234, 32'd500, 32'h0);
    // decrease onto an equal expiry, lands behind it
    send_item(OP_ADJUST, 16'hffff, 32'd500, 32'h0);
    send_item(OP_ADJUST, 16'h0000, 32'd1000, 32'h0);
    send_item(OP_DELETE, 16'h1234, 32'h0, 32'h0);
    send_item(OP_TICK,   16'h0000, 32'h0, 32'd499);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < CAPACITY - 2; i++) begin
      send_item(OP_INSERT, 16'h0100 + i[15:0], 32'd100 * i + $urandom_range(150), 32'h0);
    end
    send_item(OP_INSERT, 16'hbeef, 32'd7, 32'h0);
    send_item(OP_ADJUST, 16'hcafe, 32'd7, 32'h0);
    send_item(OP_ADJUST, 16'h0103, 32'd0, 32'h0);
    send_item(OP_TICK,   16'h0000, 32'h0, 32'hffff_ffff);
  endtask

  task automatic test_random_traffic(int count);
    int roll;
    stq_op_e op;
    logic [HANDLE_W-1:0] h;
    logic [TIME_W-1:0] e;
    logic [TIME_W-1:0] now;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        op  = stq_op_e'($urandom_range(3));
        h   = HANDLE_W'($urandom);
        e   = $urandom;
        now = $urandom;
      end else begin
        h   = handle_pool[$urandom_range(POOL_SIZE - 1)];
        e   = clock_now + $urandom_range(200);
        now = clock_now;
        roll = $urandom_range(99);
        if (roll < 35) begin
          op = OP_INSERT;
        end else if (roll < 55) begin
          op = OP_ADJUST;
        end else if (roll < 75) begin
          op = OP_DELETE;
        end else begin
          op = OP_TICK;
          clock_now = clock_now + $urandom_range(60);
          now = clock_now;
        end
      end
      send_item(op, h, e, now);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !quiet_run && ($urandom_range(99) < 6);
  end

  always @(posedge clk_i) begin : check_results
    timer_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected item: kind %0d handle %h expiry %h last %b",
                   kind_o, result_handle_o, result_expiry_o, last_o);
        end
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (want.kind == KIND_EXPIRED) expired_seen++;
        if (kind_o !== want.kind || result_handle_o !== want.handle ||
            result_expiry_o !== want.expiry || last_o !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch (exp/act): kind %0d/%0d handle %h/%h expiry %h/%h last %b/%b",
                     want.kind, kind_o, want.handle, result_handle_o,
                     want.expiry, result_expiry_o, want.last, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, due_results.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    list_count = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      list_handle[i] = '0;
      list_expiry[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) handle_pool[i] = HANDLE_W'($urandom);
    clock_now = $urandom_range(1000);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_store();
    test_order_and_adjust();
    test_full_store();
    quiet_run = 1'b1;
    test_random_traffic(20);
    quiet_run = 1'b0;
    // sender holds off until every result is back
    wait_drained();
    test_random_traffic(50);
    wait_drained();

    $display("summary: %0d items accepted, %0d results checked, %0d expired timers seen",
             items_accepted, results_checked, expired_seen);
    $display("summary: insert, adjust, delete, tick, duplicate, full store, not found, burst");
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
